/* sv/soa_pkg.sv */
// Shared types and constants for the subregion ownership allocator.
// No dependencies.
package soa_pkg;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOMEM  = 2'd1,
    ST_BADARG = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CLS_DDR     = 2'd0,
    CLS_HBM_PIN = 2'd1,
    CLS_HBM_ANY = 2'd2,
    CLS_INVALID = 2'd3
  } mem_class_t;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_t;

  localparam logic [0:0] CFG_DDR_BASE = 1'b0;
  localparam logic [0:0] CFG_HBM_BASE = 1'b1;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_CHECK,
    BK_WRITE,
    BK_DONE
  } bk_state_t;

endpackage

/* sv/soa_front.sv */
// Front end: accepts requests, checks arguments and forms a scan command.
// Depends on soa_pkg.
module soa_front #(
  parameter int DDR_REGION_COUNT    = 4,
  parameter int HBM_REGION_COUNT    = 64,
  parameter int SUBREGIONS_IN_REGION = 8,
  parameter int SUBREGION_SHIFT     = 26,
  parameter int SW = (SUBREGIONS_IN_REGION > 1) ? $clog2(SUBREGIONS_IN_REGION) : 1,
  parameter int NW = $clog2(SUBREGIONS_IN_REGION + 1),
  parameter int RW = ((DDR_REGION_COUNT > HBM_REGION_COUNT ? DDR_REGION_COUNT
                                                           : HBM_REGION_COUNT) > 1)
                   ? $clog2(DDR_REGION_COUNT > HBM_REGION_COUNT ? DDR_REGION_COUNT
                                                                : HBM_REGION_COUNT)
                   : 1
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_kind,
  input  logic [1:0]  in_mem_class,
  input  logic [63:0] in_request_size,
  input  logic [7:0]  in_region_select,
  input  logic [15:0] in_owner_id,
  input  logic [63:0] in_free_address,
  input  logic [63:0] ddr_base,
  input  logic [63:0] hbm_base,
  input  logic        q_full,
  output logic        q_push,
  output logic        cmd_bad,
  output logic        cmd_kind,
  output logic        cmd_hbm,
  output logic [RW-1:0] cmd_first,
  output logic [RW-1:0] cmd_last,
  output logic [SW-1:0] cmd_start,
  output logic [NW-1:0] cmd_len,
  output logic [15:0] cmd_owner,
  output logic [63:0] cmd_base,
  output logic        busy
);
  import soa_pkg::*;

  localparam int OFFW = SUBREGION_SHIFT + SW + RW;
  // Subregion index width and the reciprocal used to split it into region and slot
  localparam int QW   = OFFW - SUBREGION_SHIFT;
  localparam int KSH  = QW + 7;
  localparam int PW   = QW + KSH + 1;
  localparam logic [PW-1:0] RECIP =
    PW'(((64'd1 << KSH) + 64'(SUBREGIONS_IN_REGION) - 64'd1) / 64'(SUBREGIONS_IN_REGION));

  // Registered request and stage flag
  logic        v_r;
  logic        kind_r;
  logic [1:0]  cls_r;
  logic [63:0] size_r, faddr_r;
  logic [7:0]  sel_r;
  logic [15:0] owner_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_valid && !busy) begin
      v_r <= 1'b1;
    end else if (q_push) begin
      v_r <= 1'b0;
    end
    if (in_valid && !busy) begin
      kind_r  <= in_kind;
      cls_r   <= in_mem_class;
      size_r  <= in_request_size;
      faddr_r <= in_free_address;
      sel_r   <= in_region_select;
      owner_r <= in_owner_id;
    end
  end

  assign busy   = v_r;
  assign q_push = v_r && !q_full;

  // Classify the request
  logic [63:0] nsub, base, off, span;
  logic        rem_nz, hbm, bad;
  logic [OFFW-1:0] off_n;
  logic [QW-1:0] qsub;
  logic [PW-1:0] rprod;
  logic [RW-1:0] reg_idx;
  logic [SW-1:0] st;

  always_comb begin
    rem_nz = |size_r[SUBREGION_SHIFT-1:0];
    nsub   = (size_r >> SUBREGION_SHIFT) + {63'd0, rem_nz};
    hbm    = (cls_r != CLS_DDR);
    base   = hbm ? hbm_base : ddr_base;
    span   = hbm ? (64'(HBM_REGION_COUNT) * 64'(SUBREGIONS_IN_REGION)) << SUBREGION_SHIFT
                 : (64'(DDR_REGION_COUNT) * 64'(SUBREGIONS_IN_REGION)) << SUBREGION_SHIFT;
    off    = faddr_r - base;
    off_n  = off[OFFW-1:0];
    // Split the subregion index into region and slot by reciprocal multiply
    qsub    = off_n[OFFW-1:SUBREGION_SHIFT];
    rprod   = PW'(qsub) * RECIP;
    reg_idx = RW'(rprod >> KSH);
    st      = SW'(qsub - QW'(reg_idx) * QW'(SUBREGIONS_IN_REGION));
    bad = (size_r == 64'd0) || (owner_r == 16'd0) || (cls_r == CLS_INVALID)
       || (nsub > 64'(SUBREGIONS_IN_REGION));
    if (kind_r == KIND_ALLOC) begin
      if (cls_r == CLS_HBM_PIN && {1'b0, sel_r} >= 9'(HBM_REGION_COUNT)) bad = 1'b1;
    end else begin
      if (faddr_r < base || off >= span || |off[SUBREGION_SHIFT-1:0]) bad = 1'b1;
      if (64'(st) + nsub > 64'(SUBREGIONS_IN_REGION)) bad = 1'b1;
    end
  end

  assign cmd_bad   = bad;
  assign cmd_kind  = kind_r;
  assign cmd_hbm   = hbm;
  assign cmd_len   = NW'(nsub);
  assign cmd_owner = owner_r;
  assign cmd_base  = base;
  assign cmd_start = st;

  always_comb begin
    if (kind_r == KIND_FREE) begin
      cmd_first = reg_idx;
      cmd_last  = reg_idx;
    end else if (cls_r == CLS_HBM_PIN) begin
      cmd_first = RW'(sel_r);
      cmd_last  = RW'(sel_r);
    end else if (hbm) begin
      cmd_first = '0;
      cmd_last  = RW'(HBM_REGION_COUNT - 1);
    end else begin
      cmd_first = '0;
      cmd_last  = RW'(DDR_REGION_COUNT - 1);
    end
  end
endmodule

/* sv/soa_back.sv */
// Back end: owner tables, region scan, stamp or clear, result strobe.
// Depends on soa_pkg.
module soa_back #(
  parameter int DDR_REGION_COUNT    = 4,
  parameter int HBM_REGION_COUNT    = 64,
  parameter int SUBREGIONS_IN_REGION = 8,
  parameter int SUBREGION_SHIFT     = 26,
  parameter int SW = 3,
  parameter int NW = 4,
  parameter int RW = 6,
  parameter int CW = 1 + 1 + 1 + RW + RW + SW + NW + 16 + 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  logic [CW-1:0] q_data,
  output logic          q_pop,
  output logic          out_valid,
  output logic [1:0]    out_status,
  output logic [63:0]   out_base_address,
  output logic [63:0]   out_granted_size
);
  import soa_pkg::*;

  localparam int S   = SUBREGIONS_IN_REGION;
  localparam int RWD = S * 16;
  localparam int DAW = (DDR_REGION_COUNT > 1) ? $clog2(DDR_REGION_COUNT) : 1;
  localparam int HAW = (HBM_REGION_COUNT > 1) ? $clog2(HBM_REGION_COUNT) : 1;
  localparam int NROWS = (DDR_REGION_COUNT > HBM_REGION_COUNT) ? DDR_REGION_COUNT
                                                               : HBM_REGION_COUNT;

  // Unpack command
  logic          c_bad, c_kind, c_hbm;
  logic [RW-1:0] c_first, c_last;
  logic [SW-1:0] c_start;
  logic [NW-1:0] c_len;
  logic [15:0]   c_owner;
  logic [63:0]   c_base;
  assign {c_bad, c_kind, c_hbm, c_first, c_last, c_start, c_len, c_owner, c_base} = q_data;

  // Row memories, one row per region
  logic [RWD-1:0] ddr_mem [DDR_REGION_COUNT];
  logic [RWD-1:0] hbm_mem [HBM_REGION_COUNT];
  logic [RWD-1:0] ddr_q_r, hbm_q_r, row_r, rd_row;

  bk_state_t     state_r, state_nxt;
  logic [RW-1:0] reg_r, reg_nxt;
  logic [RW:0]   clr_r;
  logic [SW-1:0] hit_r, hit_nxt;
  logic [1:0]    st_r, st_nxt;
  logic          we, clearing;
  logic [RWD-1:0] wrow;

  assign clearing = (clr_r != (RW+1)'(NROWS));

  // Memory ports; after reset the clearing pass zeroes the rows in turn
  always_ff @(posedge clk) begin
    if (clearing) begin
      if (clr_r < (RW+1)'(HBM_REGION_COUNT)) hbm_mem[HAW'(clr_r)] <= '0;
      if (clr_r < (RW+1)'(DDR_REGION_COUNT)) ddr_mem[DAW'(clr_r)] <= '0;
    end else if (we) begin
      if (c_hbm) hbm_mem[HAW'(reg_r)] <= wrow;
      else ddr_mem[DAW'(reg_r)] <= wrow;
    end
    ddr_q_r <= ddr_mem[DAW'(reg_r)];
    hbm_q_r <= hbm_mem[HAW'(reg_r)];
  end

  assign rd_row = c_hbm ? hbm_q_r : ddr_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r   <= '0;
      state_r <= BK_IDLE;
    end else begin
      if (clearing) clr_r <= clr_r + 1'b1;
      state_r <= state_nxt;
    end
    reg_r <= reg_nxt;
    hit_r <= hit_nxt;
    st_r  <= st_nxt;
    if (state_r == BK_CHECK) row_r <= rd_row;
  end

  // First fit within the row just read
  logic [S-1:0] free_b, own_b, mask, ok_mask;
  logic         found;
  logic [SW-1:0] fpos;
  always_comb begin
    found = 1'b0;
    fpos  = '0;
    for (int i = 0; i < S; i++) begin
      free_b[i] = (rd_row[16*i +: 16] == 16'd0);
      own_b[i]  = (rd_row[16*i +: 16] == c_owner);
    end
    for (int p = S-1; p >= 0; p--) begin
      mask = '0;
      for (int k = 0; k < S; k++)
        if (k >= p && k < p + int'(c_len)) mask[k] = 1'b1;
      if (p + int'(c_len) <= S && (free_b & mask) == mask) begin
        found = 1'b1;
        fpos  = SW'(p);
      end
    end
    ok_mask = '0;
    for (int k = 0; k < S; k++)
      if (k >= int'(c_start) && k < int'(c_start) + int'(c_len)) ok_mask[k] = 1'b1;
  end

  // Stamp or clear the chosen span
  always_comb begin
    wrow = row_r;
    for (int k = 0; k < S; k++) begin
      if (c_kind == KIND_ALLOC) begin
        if (k >= int'(hit_r) && k < int'(hit_r) + int'(c_len)) wrow[16*k +: 16] = c_owner;
      end else if (ok_mask[k]) begin
        wrow[16*k +: 16] = 16'd0;
      end
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    reg_nxt   = reg_r;
    hit_nxt   = hit_r;
    st_nxt    = st_r;
    we        = 1'b0;
    q_pop     = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (q_valid && !clearing) begin
          reg_nxt = c_first;
          if (c_bad) begin
            st_nxt = ST_BADARG;
            state_nxt = BK_DONE;
          end else begin
            state_nxt = BK_READ;
          end
        end
      end
      BK_READ: state_nxt = BK_CHECK;
      BK_CHECK: begin
        if (c_kind == KIND_FREE) begin
          if ((own_b & ok_mask) == ok_mask) begin
            st_nxt = ST_OK;
            state_nxt = BK_WRITE;
          end else begin
            st_nxt = ST_BADARG;
            state_nxt = BK_DONE;
          end
        end else if (found) begin
          hit_nxt = fpos;
          st_nxt  = ST_OK;
          state_nxt = BK_WRITE;
        end else if (reg_r == c_last) begin
          st_nxt = ST_NOMEM;
          state_nxt = BK_DONE;
        end else begin
          reg_nxt = reg_r + 1'b1;
          state_nxt = BK_READ;
        end
      end
      BK_WRITE: begin
        we = 1'b1;
        state_nxt = BK_DONE;
      end
      BK_DONE: begin
        q_pop = 1'b1;
        state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Result register, one strobe per request
  logic [127:0] prod;
  assign prod = 128'(reg_r) * 128'(S);
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= (state_r == BK_DONE);
    out_status <= st_r;
    if (state_r == BK_DONE && st_r == ST_OK && c_kind == KIND_ALLOC) begin
      out_base_address <= c_base + ((64'(prod) + 64'(hit_r)) << SUBREGION_SHIFT);
      out_granted_size <= 64'(c_len) << SUBREGION_SHIFT;
    end else begin
      out_base_address <= '0;
      out_granted_size <= '0;
    end
  end
endmodule

/* sv/subregion_ownership_allocator.sv */
// Top level of the subregion ownership allocator.
// Depends on soa_pkg, soa_front and soa_back.
//
// Usage: pulse start with a request on the in_ ports while busy is low.
// The front stage registers and classifies the request, a one-entry queue
// hands it to the back end, which reads one region row of owner words per
// visit, scans it for the first fitting free run (allocate) or checks the
// owners of the span (free), and writes the stamped or cleared row back.
// A rejected request goes to the result strobe without reading a row; when
// no fit is found or a free fails the owner check, no row is written.
// A pinned allocate or a free reads one row; an HBM any-region allocate
// that fails reads every HBM row.
// busy drops once the command is in the queue; one request is in service
// at a time. Each request yields one result on out_valid for one cycle;
// the receiver cannot stall it.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 DDR base,
// 1 HBM base) and cfg_data; cfg_ready is always high.
// After reset the owner tables are cleared by a pass over the rows of the
// larger region count; requests wait in the queue until it ends.
module subregion_ownership_allocator #(
  parameter int DDR_REGION_COUNT     = 4,
  parameter int HBM_REGION_COUNT     = 64,
  parameter int SUBREGIONS_IN_REGION = 8,
  parameter int SUBREGION_SHIFT      = 26
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_kind,
  input  logic [1:0]  in_mem_class,
  input  logic [63:0] in_request_size,
  input  logic [7:0]  in_region_select,
  input  logic [15:0] in_owner_id,
  input  logic [63:0] in_free_address,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [63:0] out_base_address,
  output logic [63:0] out_granted_size
);
  import soa_pkg::*;

  localparam int MAXRC = (DDR_REGION_COUNT > HBM_REGION_COUNT) ? DDR_REGION_COUNT
                                                               : HBM_REGION_COUNT;
  localparam int SW = (SUBREGIONS_IN_REGION > 1) ? $clog2(SUBREGIONS_IN_REGION) : 1;
  localparam int NW = $clog2(SUBREGIONS_IN_REGION + 1);
  localparam int RW = (MAXRC > 1) ? $clog2(MAXRC) : 1;
  localparam int CW = 3 + RW + RW + SW + NW + 16 + 64;

  // Base address registers
  logic [63:0] ddr_base_r, hbm_base_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ddr_base_r <= '0;
      hbm_base_r <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_DDR_BASE) ddr_base_r <= cfg_data;
      else hbm_base_r <= cfg_data;
    end
  end

  logic          f_busy, q_push, q_pop;
  logic          c_bad, c_kind, c_hbm;
  logic [RW-1:0] c_first, c_last;
  logic [SW-1:0] c_start;
  logic [NW-1:0] c_len;
  logic [15:0]   c_owner;
  logic [63:0]   c_base;
  logic          q_v_r;
  logic [CW-1:0] q_d_r;

  soa_front #(
    .DDR_REGION_COUNT(DDR_REGION_COUNT), .HBM_REGION_COUNT(HBM_REGION_COUNT),
    .SUBREGIONS_IN_REGION(SUBREGIONS_IN_REGION), .SUBREGION_SHIFT(SUBREGION_SHIFT),
    .SW(SW), .NW(NW), .RW(RW)
  ) u_front (
    .clk, .rst_n, .in_valid(start), .in_kind, .in_mem_class, .in_request_size,
    .in_region_select, .in_owner_id, .in_free_address,
    .ddr_base(ddr_base_r), .hbm_base(hbm_base_r), .q_full(q_v_r), .q_push,
    .cmd_bad(c_bad), .cmd_kind(c_kind), .cmd_hbm(c_hbm), .cmd_first(c_first),
    .cmd_last(c_last), .cmd_start(c_start), .cmd_len(c_len), .cmd_owner(c_owner),
    .cmd_base(c_base), .busy(f_busy)
  );

  // One-entry command queue
  always_ff @(posedge clk) begin
    if (!rst_n) q_v_r <= 1'b0;
    else if (q_push) q_v_r <= 1'b1;
    else if (q_pop) q_v_r <= 1'b0;
    if (q_push)
      q_d_r <= {c_bad, c_kind, c_hbm, c_first, c_last, c_start, c_len, c_owner, c_base};
  end

  assign busy = f_busy;

  soa_back #(
    .DDR_REGION_COUNT(DDR_REGION_COUNT), .HBM_REGION_COUNT(HBM_REGION_COUNT),
    .SUBREGIONS_IN_REGION(SUBREGIONS_IN_REGION), .SUBREGION_SHIFT(SUBREGION_SHIFT),
    .SW(SW), .NW(NW), .RW(RW), .CW(CW)
  ) u_back (
    .clk, .rst_n, .q_valid(q_v_r), .q_data(q_d_r), .q_pop,
    .out_valid, .out_status, .out_base_address, .out_granted_size
  );
endmodule
